// ----- rtl/smed_pkg.sv -----
package smed_pkg;

  localparam int unsigned DEPTH_DEF        = 64;
  localparam int unsigned SAMPLE_WIDTH_DEF = 32;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned MEDIAN_W = 32;
  localparam int unsigned COUNT_W  = 7;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_EMPTY   = 2'd1,
    STATUS_DROPPED = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SHIFT = 4'b0010,
    ST_SUM   = 4'b0100,
    ST_OUT   = 4'b1000
  } state_e;

  typedef struct packed {
    logic                       action;
    logic signed [SAMPLE_W-1:0] sample;
  } in_t;

  typedef struct packed {
    logic signed [MEDIAN_W-1:0] median_value;
    logic [COUNT_W-1:0]         sample_count;
    status_e                    status;
  } out_t;

  // Commands broadcast to every cell of the chain
  typedef struct packed {
    logic insert;
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

// ----- rtl/smed_cell.sv -----
module smed_cell import smed_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cell_ctrl_t                     ctrl_i,
  input  logic signed [SAMPLE_WIDTH-1:0] new_val_i,
  input  logic signed [SAMPLE_WIDTH-1:0] prev_val_i,
  input  logic                           prev_valid_i,
  input  logic                           prev_gt_i,
  input  logic signed [SAMPLE_WIDTH-1:0] next_val_i,
  output logic signed [SAMPLE_WIDTH-1:0] val_o,
  output logic                           valid_o,
  output logic                           gt_o
);

  logic signed [SAMPLE_WIDTH-1:0] val_q, val_d;
  logic                           valid_q, valid_d;
  logic                           gt;

  // Strictly greater: an equal sample lands behind existing ones
  assign gt = valid_q && (val_q > new_val_i);

  always_comb begin
    val_d   = val_q;
    valid_d = valid_q;
    if (ctrl_i.insert) begin
      if (prev_gt_i) begin
        // take the neighbor's entry, it was displaced by the new sample
        val_d   = prev_val_i;
        valid_d = 1'b1;
      end else if ((gt || !valid_q) && prev_valid_i) begin
        val_d   = new_val_i;
        valid_d = 1'b1;
      end
    end
    if (ctrl_i.shift) begin
      val_d = next_val_i;
    end
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o   = val_q;
  assign valid_o = valid_q;
  assign gt_o    = gt;

endmodule

// ----- rtl/set_median_core.sv -----
// Median of a set of signed samples, held sorted in a chain of DEPTH insertion
// cells. Add transfers are taken while the block is idle and the next one may
// follow at once; every cell compares against the new sample in parallel and
// the larger entries move up by one cell. Adds beyond DEPTH are discarded and
// reported as dropped status at the next finish. A finish transfer empties the
// set and keeps the block busy: the chain shifts down one cell per cycle until
// the middle entries sit in cell 0 (and cell 1 for an even count), then ST_SUM
// adds them and ST_OUT registers half the sum as the result; an empty set goes
// straight to ST_OUT. ST_OUT is held for as long as an earlier result still
// waits on the output. Adds are taken while a finished result waits on the output.
module set_median_core import smed_pkg::*; #(
  parameter int unsigned DEPTH        = DEPTH_DEF,
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned IDX1 = (DEPTH > 1) ? 1 : 0;

  state_e                         state_q, state_d;
  logic [CW-1:0]                  count_q, count_d;
  logic                           drop_q, drop_d;
  logic [CW-1:0]                  fin_cnt_q, fin_cnt_d;
  logic                           fin_drop_q, fin_drop_d;
  logic [CW-1:0]                  shift_q, shift_d;
  logic signed [SAMPLE_WIDTH:0]   sum_q, sum_d;
  logic                           out_valid_q, out_valid_d;
  out_t                           out_q, out_d;

  cell_ctrl_t                     ctrl;
  logic                           in_fire;
  logic                           full;
  logic [CW-1:0]                  mid;
  logic signed [SAMPLE_WIDTH-1:0] new_val;
  logic signed [SAMPLE_WIDTH-1:0] low_val, high_val;
  logic signed [SAMPLE_WIDTH:0]   half;
  logic                           slot_free;

  logic signed [SAMPLE_WIDTH-1:0] vals   [DEPTH];
  logic [DEPTH-1:0]               valids;
  logic [DEPTH-1:0]               gts;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign full       = (count_q == CW'(DEPTH));
  assign mid        = count_q >> 1;
  assign new_val    = SAMPLE_WIDTH'(in_data_i.sample);
  assign slot_free  = !out_valid_q || out_ready_i;

  assign low_val  = vals[0];
  assign high_val = fin_cnt_q[0] ? vals[0] : vals[IDX1];
  // truncate toward zero: bias negative sums by one before the shift
  assign half     = (sum_q + $signed({{SAMPLE_WIDTH{1'b0}}, sum_q[SAMPLE_WIDTH]})) >>> 1;

  for (genvar i = 0; i < DEPTH; i++) begin : g_chain
    logic signed [SAMPLE_WIDTH-1:0] prev_val;
    logic                           prev_valid;
    logic                           prev_gt;
    logic signed [SAMPLE_WIDTH-1:0] next_val;

    if (i == 0) begin : g_head
      assign prev_val   = new_val;
      assign prev_valid = 1'b1;
      assign prev_gt    = 1'b0;
    end else begin : g_body
      assign prev_val   = vals[i-1];
      assign prev_valid = valids[i-1];
      assign prev_gt    = gts[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_val = vals[i];
    end else begin : g_mid
      assign next_val = vals[i+1];
    end

    smed_cell #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .new_val_i   (new_val),
      .prev_val_i  (prev_val),
      .prev_valid_i(prev_valid),
      .prev_gt_i   (prev_gt),
      .next_val_i  (next_val),
      .val_o       (vals[i]),
      .valid_o     (valids[i]),
      .gt_o        (gts[i])
    );
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    drop_d      = drop_q;
    fin_cnt_d   = fin_cnt_q;
    fin_drop_d  = fin_drop_q;
    shift_d     = shift_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ctrl        = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire && !in_data_i.action) begin
          if (full) begin
            drop_d = 1'b1;
          end else begin
            ctrl.insert = 1'b1;
            count_d     = count_q + CW'(1);
          end
        end else if (in_fire) begin
          ctrl.clear = 1'b1;
          fin_cnt_d  = count_q;
          fin_drop_d = drop_q;
          count_d    = '0;
          drop_d     = 1'b0;
          // shifts needed to bring the lower middle entry into cell 0
          shift_d    = count_q[0] ? mid : mid - CW'(1);
          if (count_q == '0) begin
            sum_d   = '0;
            state_d = ST_OUT;
          end else if (shift_d == '0) begin
            state_d = ST_SUM;
          end else begin
            state_d = ST_SHIFT;
          end
        end
      end
      ST_SHIFT: begin
        ctrl.shift = 1'b1;
        shift_d    = shift_q - CW'(1);
        if (shift_q == CW'(1)) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        sum_d   = (SAMPLE_WIDTH + 1)'(low_val) + (SAMPLE_WIDTH + 1)'(high_val);
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (slot_free) begin
          out_d.median_value = MEDIAN_W'(half);
          out_d.sample_count = COUNT_W'(fin_cnt_q);
          if (fin_cnt_q == '0) begin
            out_d.status = STATUS_EMPTY;
          end else if (fin_drop_q) begin
            out_d.status = STATUS_DROPPED;
          end else begin
            out_d.status = STATUS_OK;
          end
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fin_cnt_q  <= fin_cnt_d;
    fin_drop_q <= fin_drop_d;
    shift_q    <= shift_d;
    sum_q      <= sum_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("kept count above depth");

  a_valid_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> ($countones(valids) == int'(count_q)))
    else $error("occupied cells disagree with kept count");

  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.action) |=> (count_q == '0 && valids == '0 && !drop_q))
    else $error("set not cleared after finish");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT))
    else $error("result raised outside output step");

  for (genvar j = 0; j + 1 < DEPTH; j++) begin : g_order_chk
    a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == ST_IDLE && valids[j+1]) |-> (valids[j] && vals[j] <= vals[j+1]))
      else $error("chain out of order");
  end

endmodule
